FILE: rtl/lcas_pkg.sv
// Shared constants and control types for the LFSR correlation search block.
`default_nettype none

package lcas_pkg;

    localparam int MAX_STAGES_DEF = 16;
    localparam int MAX_BITS_DEF   = 256;

    localparam int LEN_W      = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_LFSR_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_MASK    = 1'b1;

    localparam logic [LEN_W-1:0] LEN_RESET = 5'd9;

    typedef struct packed {
        logic load;
        logic advance;
    } lfsr_ctl_t;

    typedef struct packed {
        logic clear_run;
        logic step;
        logic hit;
        logic clear_best;
        logic judge;
    } score_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/lcas_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lcas_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/lcas_lfsr.sv
// Candidate shift register: loads a seed and clocks one feedback step per cycle while advance is set.
`default_nettype none

module lcas_lfsr #(
    parameter int MAX_STAGES = lcas_pkg::MAX_STAGES_DEF
) (
    input  wire logic                  clk,
    input  wire lcas_pkg::lfsr_ctl_t   ctl,
    input  wire logic [MAX_STAGES-1:0] seed,
    input  wire logic [MAX_STAGES-1:0] len_mask,
    input  wire logic [MAX_STAGES-2:0] taps,
    output logic                       out_bit
);

    import lcas_pkg::*;

    logic [MAX_STAGES-1:0] sr_reg;
    logic [MAX_STAGES-1:0] sr_next;
    logic [MAX_STAGES-1:0] tap_eff;
    logic [MAX_STAGES-1:0] top_sel;
    logic                  fb;

    always_comb
    begin
        tap_eff = {1'b0, taps} & (len_mask >> 1);
        top_sel = len_mask & ~(len_mask >> 1);
        out_bit = |(sr_reg & top_sel);
        fb      = (^(sr_reg & tap_eff)) ^ out_bit;
        sr_next = sr_reg;
        if (ctl.load)
        begin
            sr_next = seed;
        end
        else if (ctl.advance)
        begin
            sr_next = ((sr_reg << 1) | {{(MAX_STAGES-1){1'b0}}, fb}) & len_mask;
        end
    end

    always_ff @(posedge clk)
    begin
        sr_reg <= sr_next;
    end

endmodule

`default_nettype wire

FILE: rtl/lcas_score.sv
// Running match score and best-candidate tracker.
`default_nettype none

module lcas_score #(
    parameter int MAX_STAGES = lcas_pkg::MAX_STAGES_DEF,
    parameter int MAX_BITS   = lcas_pkg::MAX_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire lcas_pkg::score_ctl_t                  ctl,
    input  wire logic [MAX_STAGES-1:0]                 cand,
    output logic      [MAX_STAGES-1:0]                 best_cand,
    output logic signed [$clog2(MAX_BITS+1):0]         best_val
);

    import lcas_pkg::*;

    localparam int SW = $clog2(MAX_BITS + 1) + 1;

    logic signed [SW-1:0]   run_reg;
    logic signed [SW-1:0]   run_next;
    logic signed [SW-1:0]   bval_reg;
    logic signed [SW-1:0]   bval_next;
    logic [MAX_STAGES-1:0]  bcand_reg;
    logic [MAX_STAGES-1:0]  bcand_next;
    logic [SW-1:0]          run_mag;
    logic [SW-1:0]          best_mag;

    always_comb
    begin
        run_mag    = run_reg[SW-1]  ? (~run_reg + 1'b1)  : run_reg;
        best_mag   = bval_reg[SW-1] ? (~bval_reg + 1'b1) : bval_reg;
        run_next   = run_reg;
        bval_next  = bval_reg;
        bcand_next = bcand_reg;
        if (ctl.clear_run)
        begin
            run_next = '0;
        end
        else if (ctl.step)
        begin
            run_next = run_reg + (ctl.hit ? SW'(1) : {SW{1'b1}});
        end
        if (ctl.clear_best)
        begin
            bval_next  = '0;
            bcand_next = '0;
        end
        else if (ctl.judge && (run_mag > best_mag))
        begin
            bval_next  = run_reg;
            bcand_next = cand;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= '0;
            bval_reg  <= '0;
            bcand_reg <= '0;
        end
        else
        begin
            run_reg   <= run_next;
            bval_reg  <= bval_next;
            bcand_reg <= bcand_next;
        end
    end

    assign best_cand = bcand_reg;
    assign best_val  = bval_reg;

endmodule

`default_nettype wire

FILE: rtl/lfsr_correlation_attack_search.sv
// Top level: keystream bit store and exhaustive LFSR correlation search.
//
//  channel  | direction | handshake                | word
//  ---------+-----------+--------------------------+-------------------------------------
//  item     | in        | item_valid / item_stall   | keystream_bit, last_bit
//  result   | out       | result_valid / result_stall | best_state, best_score, truncated
//  cfg      | in        | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// Bits load at one per cycle into the keystream RAM while item_stall is low. A word
// with last_bit starts the search: each of the 2^L candidates is loaded, warmed up by
// LFSR steps, scored against the stored bits (one RAM read and one LFSR step per cycle)
// and judged. item_stall is high for the whole search.
// Reset sets L to 9 and the taps to zero; the RAM is not cleared. A held result
// does not block loading of the next block; only the final hand-off waits for it.
`default_nettype none

module lfsr_correlation_attack_search #(
    parameter int MAX_STAGES = lcas_pkg::MAX_STAGES_DEF,
    parameter int MAX_BITS   = lcas_pkg::MAX_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                item_valid,
    output logic                                     item_stall,
    input  wire logic                                keystream_bit,
    input  wire logic                                last_bit,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output logic      [MAX_STAGES-1:0]               best_state,
    output logic signed [$clog2(MAX_BITS+1):0]       best_score,
    output logic                                     truncated,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [lcas_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [lcas_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import lcas_pkg::*;

    localparam int SW = $clog2(MAX_BITS + 1) + 1;
    localparam int CW = $clog2(MAX_BITS + 1);
    localparam int AW = $clog2(MAX_BITS);
    localparam int LW = $clog2(MAX_STAGES + 1);
    localparam int WW = $clog2(MAX_STAGES);
    localparam int TW = MAX_STAGES - 1;

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_WARM  = 3'd1;
    localparam logic [2:0] S_SCORE = 3'd2;
    localparam logic [2:0] S_JUDGE = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0]             state_reg,  state_next;
    logic [LEN_W-1:0]       len_reg,    len_next;
    logic [TW-1:0]          tap_reg,    tap_next;
    logic [CW-1:0]          count_reg,  count_next;
    logic                   ovf_reg,    ovf_next;
    logic [MAX_STAGES-1:0]  cand_reg,   cand_next;
    logic [WW-1:0]          warm_reg,   warm_next;
    logic [AW-1:0]          pos_reg,    pos_next;
    logic                   rvalid_reg, rvalid_next;
    logic [MAX_STAGES-1:0]  rstate_reg, rstate_next;
    logic signed [SW-1:0]   rscore_reg, rscore_next;
    logic                   rtrunc_reg, rtrunc_next;

    logic [LW-1:0]          len_eff;
    logic [MAX_STAGES-1:0]  len_mask;
    logic                   cand_last;
    logic                   item_take;
    logic                   out_free;
    logic                   ram_we;
    logic [AW-1:0]          ram_raddr;
    logic                   ram_rdata;
    logic                   lfsr_out;
    logic [MAX_STAGES-1:0]  seed;
    lfsr_ctl_t              lfsr_ctl;
    score_ctl_t             score_ctl;
    logic [MAX_STAGES-1:0]  best_cand;
    logic signed [SW-1:0]   best_val;

    always_comb
    begin
        if (len_reg < LEN_W'(2))
        begin
            len_eff = LW'(2);
        end
        else if (len_reg > LEN_W'(MAX_STAGES))
        begin
            len_eff = LW'(MAX_STAGES);
        end
        else
        begin
            len_eff = LW'(len_reg);
        end
        for (int i = 0; i < MAX_STAGES; i++)
        begin
            len_mask[i] = (LW'(i) < len_eff);
        end
    end

    assign cand_last  = &(cand_reg | ~len_mask);
    assign item_stall = (state_reg != S_LOAD);
    assign item_take  = item_valid && !item_stall;
    assign out_free   = !rvalid_reg || !result_stall;
    assign cfg_ready  = 1'b1;
    assign ram_we     = item_take && (count_reg < CW'(MAX_BITS));
    assign ram_raddr  = (state_reg == S_SCORE) ? (pos_reg + AW'(1)) : '0;

    always_comb
    begin
        state_next  = state_reg;
        len_next    = len_reg;
        tap_next    = tap_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        cand_next   = cand_reg;
        warm_next   = warm_reg;
        pos_next    = pos_reg;
        rvalid_next = rvalid_reg;
        rstate_next = rstate_reg;
        rscore_next = rscore_reg;
        rtrunc_next = rtrunc_reg;
        seed        = cand_reg + MAX_STAGES'(1);
        lfsr_ctl    = '0;
        score_ctl   = '0;
        score_ctl.hit = (lfsr_out == ram_rdata);

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_LFSR_LENGTH: len_next = cfg_data[LEN_W-1:0];
                REG_TAP_MASK:    tap_next = cfg_data[TW-1:0];
                default:         len_next = len_reg;
            endcase
        end

        if (rvalid_reg && !result_stall)
        begin
            rvalid_next = 1'b0;
        end

        case (state_reg)
            S_LOAD:
            begin
                if (item_take)
                begin
                    if (ram_we)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_bit)
                    begin
                        seed                 = '0;
                        lfsr_ctl.load        = 1'b1;
                        score_ctl.clear_run  = 1'b1;
                        score_ctl.clear_best = 1'b1;
                        cand_next            = '0;
                        warm_next            = '0;
                        state_next           = S_WARM;
                    end
                end
            end
            S_WARM:
            begin
                lfsr_ctl.advance = 1'b1;
                if (warm_reg == WW'(len_eff - LW'(1)))
                begin
                    pos_next   = '0;
                    state_next = S_SCORE;
                end
                else
                begin
                    warm_next = warm_reg + WW'(1);
                end
            end
            S_SCORE:
            begin
                lfsr_ctl.advance = 1'b1;
                score_ctl.step   = 1'b1;
                if (CW'(pos_reg) == count_reg - CW'(1))
                begin
                    state_next = S_JUDGE;
                end
                else
                begin
                    pos_next = pos_reg + AW'(1);
                end
            end
            S_JUDGE:
            begin
                score_ctl.judge = 1'b1;
                if (cand_last)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    lfsr_ctl.load       = 1'b1;
                    score_ctl.clear_run = 1'b1;
                    cand_next           = seed;
                    warm_next           = '0;
                    state_next          = S_WARM;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    rvalid_next = 1'b1;
                    rstate_next = best_cand;
                    rscore_next = best_val;
                    rtrunc_next = ovf_reg;
                    count_next  = '0;
                    ovf_next    = 1'b0;
                    state_next  = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            len_reg    <= LEN_RESET;
            tap_reg    <= '0;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            cand_reg   <= '0;
            warm_reg   <= '0;
            pos_reg    <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            tap_reg    <= tap_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            cand_reg   <= cand_next;
            warm_reg   <= warm_next;
            pos_reg    <= pos_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rstate_reg <= rstate_next;
        rscore_reg <= rscore_next;
        rtrunc_reg <= rtrunc_next;
    end

    lcas_ram #(
        .WIDTH (1),
        .DEPTH (MAX_BITS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (keystream_bit),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lcas_lfsr #(
        .MAX_STAGES (MAX_STAGES)
    ) u_lfsr (
        .clk      (clk),
        .ctl      (lfsr_ctl),
        .seed     (seed),
        .len_mask (len_mask),
        .taps     (tap_reg),
        .out_bit  (lfsr_out)
    );

    lcas_score #(
        .MAX_STAGES (MAX_STAGES),
        .MAX_BITS   (MAX_BITS)
    ) u_score (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (score_ctl),
        .cand      (cand_reg),
        .best_cand (best_cand),
        .best_val  (best_val)
    );

    assign result_valid = rvalid_reg;
    assign best_state   = rstate_reg;
    assign best_score   = rscore_reg;
    assign truncated    = rtrunc_reg;

`ifndef ASSERT_OFF
    a_last_starts_search: assert property (@(posedge clk) disable iff (!rst_n)
        item_take && last_bit |=> state_reg == S_WARM)
        else $error("search did not start after final bit");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == S_FIN))
        else $error("result raised outside finish");

    a_cand_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_LOAD |-> (cand_reg & ~len_mask) == '0)
        else $error("candidate beyond register length");

    a_pos_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCORE |-> CW'(pos_reg) < count_reg)
        else $error("score position past stored bits");
`endif

endmodule

`default_nettype wire

FILE: dv/tb_lfsr_correlation_attack_search.sv
// Self-checking bench for the LFSR correlation search: a directed plan, then random blocks.
module tb_lfsr_correlation_attack_search;
    import lcas_pkg::*;

    localparam int SW = MAX_STAGES_DEF;
    localparam int SCW = $clog2(MAX_BITS_DEF + 1) + 1;
    localparam int PLAN_LEN = 28;
    localparam int WORD_TARGET = 1850;

    typedef struct packed {
        logic [SW-1:0]         best;
        logic signed [SCW-1:0] score;
        logic                  trunc;
    } fit_t;

    typedef enum logic {ROW_REG, ROW_WORD} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [31:0]           data;
        logic                  kbit;
        logic                  last;
        logic                  typed;
        fit_t                  want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    logic keystream_bit = 1'b0;
    logic last_bit = 1'b0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic [SW-1:0] best_state;
    logic signed [SCW-1:0] best_score;
    logic truncated;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [LEN_W-1:0] len_reg = LEN_RESET;
    logic [14:0] tap_reg = '0;
    logic store [MAX_BITS_DEF];
    int fill = 0;
    logic dropped = 1'b0;
    fit_t winners_q [$];

    int faults = 0;
    int words_sent = 0;
    logic idle_on = 1'b1;
    longint budget = 0;
    longint ticks = 0;

    row_t plan [PLAN_LEN] = '{
        '{ROW_WORD, REG_LFSR_LENGTH, 32'h0, 1'b1, 1'b1, 1'b1, '{16'd0, -10'sd1, 1'b0}},
        '{ROW_WORD, REG_LFSR_LENGTH, 32'h0, 1'b0, 1'b1, 1'b1, '{16'd0, 10'sd1, 1'b0}},
        '{ROW_REG, REG_LFSR_LENGTH, 32'h0000_0000, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_REG, REG_TAP_MASK, 32'h0000_0000, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_WORD, REG_LFSR_LENGTH, 32'h0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_WORD, REG_LFSR_LENGTH, 32'h0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_WORD, REG_LFSR_LENGTH, 32'h0, 1'b1, 1'b0, 1'b0, '0},
        '{ROW_WORD, REG_LFSR_LENGTH, 32'h0, 1'b1, 1'b1, 1'b1, '{16'd0, 10'sd0, 1'b0}},
        '{ROW_REG, REG_LFSR_LENGTH, 32'h0000_0001, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_WORD, REG_LFSR_LENGTH, 32'h0, 1'b1, 1'b0, 1'b0, '0},
        '{ROW_WORD, REG_LFSR_LENGTH, 32'h0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_WORD, REG_LFSR_LENGTH, 32'h0, 1'b1, 1'b0, 1'b0, '0},
        '{ROW_WORD, REG_LFSR_LENGTH, 32'h0, 1'b1, 1'b1, 1'b0, '0},
        '{ROW_REG, REG_TAP_MASK, 32'h0000_7FFF, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_WORD, REG_LFSR_LENGTH, 32'h0, 1'b1, 1'b0, 1'b0, '0},
        '{ROW_WORD, REG_LFSR_LENGTH, 32'h0, 1'b1, 1'b0, 1'b0, '0},
        '{ROW_WORD, REG_LFSR_LENGTH, 32'h0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_WORD, REG_LFSR_LENGTH, 32'h0, 1'b1, 1'b1, 1'b0, '0},
        '{ROW_REG, REG_LFSR_LENGTH, 32'hFFFF_FFE2, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_REG, REG_TAP_MASK, 32'hFFFF_5555, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_WORD, REG_LFSR_LENGTH, 32'h0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_WORD, REG_LFSR_LENGTH, 32'h0, 1'b1, 1'b0, 1'b0, '0},
        '{ROW_WORD, REG_LFSR_LENGTH, 32'h0, 1'b1, 1'b0, 1'b0, '0},
        '{ROW_WORD, REG_LFSR_LENGTH, 32'h0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_WORD, REG_LFSR_LENGTH, 32'h0, 1'b1, 1'b1, 1'b0, '0},
        '{ROW_REG, REG_LFSR_LENGTH, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_REG, REG_TAP_MASK, 32'h8000_6B59, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_WORD, REG_LFSR_LENGTH, 32'h0, 1'b1, 1'b1, 1'b0, '0}
    };

    lfsr_correlation_attack_search dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .keystream_bit (keystream_bit),
        .last_bit      (last_bit),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .best_state    (best_state),
        .best_score    (best_score),
        .truncated     (truncated),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        ticks <= ticks + 1;
        if (ticks > 4 * budget + 200000)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int span();
        if (len_reg < 2)
            return 2;
        if (len_reg > MAX_STAGES_DEF)
            return MAX_STAGES_DEF;
        return int'(len_reg);
    endfunction

    function automatic logic [SW-1:0] lfsr_next(input logic [SW-1:0] sr, input int l,
                                                output logic out_bit);
        logic [31:0] keep;
        logic [SW-1:0] taps;
        keep = (32'd1 << l) - 1;
        taps = {1'b0, tap_reg} & (keep[SW-1:0] >> 1);
        out_bit = sr[l-1];
        return ((sr << 1) | {{(SW-1){1'b0}}, out_bit ^ (^(sr & taps))}) & keep[SW-1:0];
    endfunction

    function automatic fit_t correlate();
        fit_t f;
        int l, c, j, score, top;
        logic [SW-1:0] sr;
        logic o;
        l = span();
        top = 0;
        f = '0;
        for (c = 0; c < (1 << l); c++)
        begin
            sr = c[SW-1:0];
            for (j = 0; j < l; j++)
                sr = lfsr_next(sr, l, o);
            score = 0;
            for (j = 0; j < fill; j++)
            begin
                sr = lfsr_next(sr, l, o);
                score += (o == store[j]) ? 1 : -1;
            end
            if ((score < 0 ? -score : score) > (top < 0 ? -top : top))
            begin
                top = score;
                f.best = c[SW-1:0];
            end
        end
        f.score = top[SCW-1:0];
        f.trunc = dropped;
        return f;
    endfunction

    task automatic quiesce();
        item_valid <= 1'b0;
        while (winners_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        if (idx == REG_LFSR_LENGTH)
            len_reg = data[LEN_W-1:0];
        else
            tap_reg = data[14:0];
    endtask

    task automatic send_word(input logic b, input logic last, input logic typed,
                             input fit_t pinned);
        int gap;
        int l;
        fit_t next_fit;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        keystream_bit <= b;
        last_bit <= last;
        // hold the word until taken
        do
            @(posedge clk);
        while (item_stall !== 1'b0);
        words_sent++;
        budget += 16;
        if (fill < MAX_BITS_DEF)
        begin
            store[fill] = b;
            fill++;
        end
        else
            dropped = 1'b1;
        if (last)
        begin
            l = span();
            budget += (1 << l) * (l + fill + 2) + fill;
            if (typed)
                next_fit = pinned;
            else
                next_fit = correlate();
            winners_q = {winners_q, next_fit};
            fill = 0;
            dropped = 1'b0;
        end
    endtask

    initial
    begin : drain
        fit_t want;
        int hold;
        forever
        begin
            hold = idle_on ? $urandom_range(0, 6) : 0;
            if (hold != 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            result_stall <= 1'b0;
            do
                @(posedge clk);
            while (result_valid !== 1'b1);
            if (winners_q.size() == 0)
            begin
                $error("best_state: expected none, got %0d", best_state);
                faults++;
            end
            else
            begin
                want = winners_q.pop_front();
                if (best_state !== want.best)
                begin
                    $error("best_state: expected %0d, got %0d", want.best, best_state);
                    faults++;
                end
                if (best_score !== want.score)
                begin
                    $error("best_score: expected %0d, got %0d", $signed(want.score),
                           $signed(best_score));
                    faults++;
                end
                if (truncated !== want.trunc)
                begin
                    $error("truncated: expected %0d, got %0d", want.trunc, truncated);
                    faults++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int i, k, n, blocks, mode, l;
        logic [SW-1:0] sr;
        logic [31:0] word;
        logic o, b, fixed;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < PLAN_LEN; i++)
        begin
            if (plan[i].kind == ROW_REG)
            begin
                if (i == 0 || plan[i-1].kind != ROW_REG)
                    quiesce();
                write_reg(plan[i].idx, plan[i].data);
                if (i == PLAN_LEN - 1 || plan[i+1].kind != ROW_REG)
                    cfg_valid <= 1'b0;
            end
            else
                send_word(plan[i].kbit, plan[i].last, plan[i].typed, plan[i].want);
        end

        while (words_sent < WORD_TARGET)
        begin
            quiesce();
            idle_on = ($urandom_range(0, 3) != 0);
            word = $urandom();
            word[LEN_W-1:0] = LEN_W'(($urandom_range(0, 15) < 13) ? $urandom_range(0, 8)
                                                                   : $urandom_range(9, 10));
            write_reg(REG_LFSR_LENGTH, word);
            write_reg(REG_TAP_MASK, $urandom());
            cfg_valid <= 1'b0;
            l = span();
            blocks = $urandom_range(1, 4);
            repeat (blocks)
            begin
                if (l <= 4 && $urandom_range(0, 19) == 0)
                    n = $urandom_range(MAX_BITS_DEF - 1, MAX_BITS_DEF + 3);
                else if ($urandom_range(0, 5) == 0)
                    n = $urandom_range(25, 64);
                else
                    n = $urandom_range(1, 24);
                mode = $urandom_range(0, 3);
                fixed = 1'($urandom_range(0, 1));
                sr = SW'($urandom() & ((32'd1 << l) - 1));
                repeat (l) sr = lfsr_next(sr, l, o);
                for (k = 0; k < n; k++)
                begin
                    sr = lfsr_next(sr, l, o);
                    case (mode)
                        0: b = 1'($urandom_range(0, 1));
                        1: b = o ^ ($urandom_range(0, 7) == 0);
                        2: b = o;
                        default: b = fixed;
                    endcase
                    send_word(b, k == n - 1, 1'b0, '0);
                end
            end
        end

        quiesce();
        repeat (32) @(posedge clk);
        if (faults == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
